>>> rtl/core/eased_crossfade_defines.svh
// ----------------------------------------------------------------------------
// Eased crossfade assertion macros
// Shared macros for concurrent checks on clk_i with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef EASED_CROSSFADE_DEFINES_SVH
`define EASED_CROSSFADE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ECF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ECF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ecf_pkg.sv
// ----------------------------------------------------------------------------
// Eased crossfade package
// Default widths and sequencer state type shared by the crossfade files.
// ----------------------------------------------------------------------------
package ecf_pkg;

  // Default sample width (signed Q1.15)
  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  // Default fractional bits of the fade position (Q1.24)
  localparam int unsigned POS_FRAC_BITS_DEF = 24;

  // Sequencer states
  typedef enum logic [2:0] {
    ECF_IDLE,
    ECF_PREP,
    ECF_SQUARE,
    ECF_LOAD_CUBE,
    ECF_CUBE,
    ECF_LOAD_MIX,
    ECF_MIX,
    ECF_FINISH
  } ecf_state_e;

endpackage

>>> rtl/core/eased_crossfade.sv
// ----------------------------------------------------------------------------
// Eased crossfade
// Cubic ease-in-out crossfade between an outgoing and an incoming sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries start_fade_i, prev_value_i
//   and curr_value_i; one transaction gives exactly one output transaction on
//   (out_valid_o / out_stall_i) with mixed_value_o and fade_active_o.
//   cfg_we_i writes cfg_wdata_i into the fade step (Q1.POSITION_FRAC_BITS);
//   write it only while no sample is in flight.
//   A fading sample runs three shift-add multiplies (u*u, sq*u, diff*ease)
//   through one serial multiplier, one multiplier bit per cycle. A fading
//   sample goes through PREP, SQUARE, LOAD_CUBE, CUBE, LOAD_MIX, MIX and
//   FINISH; a sample outside a fade goes straight to FINISH. FINISH loads
//   the output register that drives out_valid_o, and the next sample is
//   taken only once the sequencer is back in IDLE.
//   The result sits in an output register: the next sample is taken while it
//   waits, and the sequencer holds in its last state while the receiver
//   stalls and the register is still full.
//   Reset clears the fade step, the fade position and the fading flag.
// ----------------------------------------------------------------------------
module eased_crossfade
  import ecf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS        = SAMPLE_BITS_DEF,
  parameter int unsigned POSITION_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [POSITION_FRAC_BITS:0]   cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_fade_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_value_i,
  input  logic signed [SAMPLE_BITS-1:0] curr_value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] mixed_value_o,
  output logic                          fade_active_o
);

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned P  = POSITION_FRAC_BITS;
  localparam int unsigned N  = P + 1;                 // multiplier bits per pass
  localparam int unsigned AW = (P > S) ? P : S;       // multiplicand width
  localparam int unsigned PW = AW + N;                // product width
  localparam int unsigned CW = $clog2(N);
  localparam logic [P:0]  POS_ONE = {1'b1, {P{1'b0}}};

  // State
  ecf_state_e          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       a_q, a_d;
  logic [N-1:0]        b_q, b_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic [P:0]          step_q;
  logic [P:0]          pos_q, pos_d;
  logic                fading_q, fading_d;
  logic [P-1:0]        u_q, u_d;
  logic                half_q, half_d;
  logic                neg_q, neg_d;
  logic [S-1:0]        prev_q, prev_d;
  logic [S-1:0]        curr_q, curr_d;
  logic                out_valid_q, out_valid_d;
  logic [S-1:0]        mixed_q, mixed_d;
  logic                active_q, active_d;
  logic                bypass_q, bypass_d;

  // Control
  logic                in_accept;
  logic                out_accept;
  logic                mul_step;
  logic                out_load;

  // Datapath helpers
  logic                fading_n;
  logic [P:0]          pos_base;
  logic [P+1:0]        pos_sum;
  logic [P:0]          pos_new;
  logic                pos_half;
  logic [P:0]          u_full;
  logic [AW:0]         mul_sum;
  logic [P:0]          core;
  logic [P:0]          ease;
  logic [S:0]          diff;
  logic [S:0]          diff_abs;
  logic [S:0]          term;
  logic [S+1:0]        mix_sum;
  logic [S-1:0]        mix_sat;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ECF_IDLE: begin
        if (in_accept) begin
          state_d = fading_n ? ECF_PREP : ECF_FINISH;
        end
      end
      ECF_PREP:      state_d = ECF_SQUARE;
      ECF_SQUARE: begin
        if (cnt_q == '0) state_d = ECF_LOAD_CUBE;
      end
      ECF_LOAD_CUBE: state_d = ECF_CUBE;
      ECF_CUBE: begin
        if (cnt_q == '0) state_d = ECF_LOAD_MIX;
      end
      ECF_LOAD_MIX:  state_d = ECF_MIX;
      ECF_MIX: begin
        if (cnt_q == '0) state_d = ECF_FINISH;
      end
      ECF_FINISH: begin
        if (!out_valid_q || !out_stall_i) state_d = ECF_IDLE;
      end
      default:       state_d = ECF_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    mul_step   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ECF_IDLE:   in_stall_o = 1'b0;
      ECF_SQUARE,
      ECF_CUBE,
      ECF_MIX:    mul_step = 1'b1;
      ECF_FINISH: out_load = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Start handling and position advance for the incoming transaction
  always_comb begin
    if (start_fade_i) begin
      fading_n = (step_q != '0);
      pos_base = (step_q != '0) ? '0 : pos_q;
    end else begin
      fading_n = fading_q;
      pos_base = pos_q;
    end
    pos_sum = {1'b0, pos_base} + {1'b0, step_q};
    pos_new = (pos_sum > {1'b0, POS_ONE}) ? POS_ONE : pos_sum[P:0];
  end

  // Fold the position about one half
  assign pos_half = pos_q[P] | pos_q[P-1];
  assign u_full   = pos_half ? (POS_ONE - pos_q) : pos_q;

  // One shift-add step of the serial multiplier
  assign mul_sum = {1'b0, prod_q[PW-1:N]} + (b_q[0] ? {1'b0, a_q} : '0);

  // Ease from the cube, and the magnitude of the sample difference
  always_comb begin
    core     = (P+1)'(prod_q[P +: AW]) << 2;
    ease     = half_q ? (POS_ONE - core) : core;
    diff     = {curr_q[S-1], curr_q} - {prev_q[S-1], prev_q};
    diff_abs = diff[S] ? (~diff + 1'b1) : diff;
  end

  // Round the mix term, add to the outgoing sample and saturate
  always_comb begin
    term    = {1'b0, prod_q[P +: S]} + (S+1)'(prod_q[P-1]);
    mix_sum = neg_q ? ({{2{prev_q[S-1]}}, prev_q} - {1'b0, term})
                    : ({{2{prev_q[S-1]}}, prev_q} + {1'b0, term});
    if ((mix_sum[S+1] == mix_sum[S]) && (mix_sum[S] == mix_sum[S-1])) begin
      mix_sat = mix_sum[S-1:0];
    end else if (mix_sum[S+1]) begin
      mix_sat = {1'b1, {(S-1){1'b0}}};
    end else begin
      mix_sat = {1'b0, {(S-1){1'b1}}};
    end
  end

  // Datapath next values
  always_comb begin
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    prod_d      = prod_q;
    pos_d       = pos_q;
    fading_d    = fading_q;
    u_d         = u_q;
    half_d      = half_q;
    neg_d       = neg_q;
    prev_d      = prev_q;
    curr_d      = curr_q;
    mixed_d     = mixed_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;

    // take the incoming transaction and update the fade state
    if (in_accept) begin
      prev_d = prev_value_i;
      curr_d = curr_value_i;
      if (fading_n) begin
        pos_d    = pos_new;
        fading_d = (pos_new != POS_ONE);
      end else begin
        fading_d = 1'b0;
      end
    end

    case (state_q)
      ECF_PREP: begin
        u_d    = u_full[P-1:0];
        half_d = pos_half;
        a_d    = AW'(u_full[P-1:0]);
        b_d    = N'(u_full[P-1:0]);
        prod_d = '0;
        cnt_d  = CW'(N - 1);
      end
      ECF_LOAD_CUBE: begin
        a_d    = prod_q[P +: AW];
        b_d    = N'(u_q);
        prod_d = '0;
        cnt_d  = CW'(N - 1);
      end
      ECF_LOAD_MIX: begin
        a_d    = AW'(diff_abs[S-1:0]);
        b_d    = ease;
        neg_d  = diff[S];
        prod_d = '0;
        cnt_d  = CW'(N - 1);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase

    // advance the multiplier by one bit
    if (mul_step) begin
      prod_d = {mul_sum, prod_q[N-1:1]};
      b_d    = b_q >> 1;
      cnt_d  = cnt_q - 1'b1;
    end

    // drop the delivered result, then load a new one
    if (out_accept) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d = 1'b1;
      mixed_d     = bypass_q ? curr_q : mix_sat;
      active_d    = fading_q;
    end
  end

  // A sample outside a fade skips the multiplies and passes curr through
  assign bypass_d = in_accept ? !fading_n : bypass_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ECF_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      pos_q       <= '0;
      fading_q    <= 1'b0;
      out_valid_q <= 1'b0;
      bypass_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      fading_q    <= fading_d;
      out_valid_q <= out_valid_d;
      bypass_q    <= bypass_d;
      if (cfg_we_i) step_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    prod_q   <= prod_d;
    u_q      <= u_d;
    half_q   <= half_d;
    neg_q    <= neg_d;
    prev_q   <= prev_d;
    curr_q   <= curr_d;
    mixed_q  <= mixed_d;
    active_q <= active_d;
  end

  assign out_valid_o   = out_valid_q;
  assign mixed_value_o = mixed_q;
  assign fade_active_o = active_q;

endmodule

>>> rtl/core/ecf_checker.sv
// ----------------------------------------------------------------------------
// Eased crossfade checker
// Port-level checks on the crossfade channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "eased_crossfade_defines.svh"

module ecf_checker
  import ecf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] mixed_value_o,
  input logic                   fade_active_o
);

  // A stalled result stays valid and unchanged
  `ECF_ASSERT_NOW(a_out_hold, $past(out_valid_o && out_stall_i), out_valid_o && $stable(mixed_value_o) && $stable(fade_active_o), "stalled output transaction changed")

  // An accepted transaction makes the block busy in the next cycle
  `ECF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken while previous sample still in work")

  // An idle block stays ready while nothing arrives
  `ECF_ASSERT_NEXT(a_idle_stays_ready, !in_valid_i && !in_stall_o, !in_stall_o, "block became busy without an input transaction")

endmodule

bind eased_crossfade ecf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ecf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mixed_value_o (mixed_value_o),
  .fade_active_o (fade_active_o)
);

>>> tb/eased_crossfade_checker.sv
// ----------------------------------------------------------------------------
// Eased crossfade checker
// Watches the fade step writes and both sample channels, predicts each
// crossfaded sample from its own copy of the fade state and compares every
// output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module eased_crossfade_checker
  import ecf_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [POS_FRAC_BITS_DEF:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                start_fade_i,
  input  logic signed [SAMPLE_BITS_DEF-1:0]   prev_value_i,
  input  logic signed [SAMPLE_BITS_DEF-1:0]   curr_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [SAMPLE_BITS_DEF-1:0]   mixed_value_i,
  input  logic                                fade_active_i,
  output int                                  error_count_o,
  output int                                  pending_o,
  output int                                  samples_o,
  output int                                  fades_begun_o,
  output int                                  fades_done_o
);

  localparam int FRAC = POS_FRAC_BITS_DEF;
  localparam int SW = SAMPLE_BITS_DEF;
  localparam longint unsigned POS_ONE = 64'd1 << FRAC;
  localparam longint unsigned POS_HALF = 64'd1 << (FRAC - 1);
  localparam longint SMP_MAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;

  typedef struct {
    logic signed [SW-1:0] mixed;
    logic                 active;
  } mixed_sample_t;

  mixed_sample_t   expected_mixes[$];
  longint unsigned step_q;
  longint unsigned position_q;
  logic            fading_q;
  int              errors;
  int              pending;
  int              samples;
  int              fades_begun;
  int              fades_done;

  assign error_count_o = errors;
  assign pending_o     = pending;
  assign samples_o     = samples;
  assign fades_begun_o = fades_begun;
  assign fades_done_o  = fades_done;

  // Advance the fade state by one sample and return the crossfaded result
  function automatic mixed_sample_t crossfade_sample(input logic start,
                                                     input logic signed [SW-1:0] prev,
                                                     input logic signed [SW-1:0] curr);
    mixed_sample_t   res;
    longint unsigned t, u, sq, cube, ease, mag, term;
    longint          diff, sum;
    sum = longint'(curr);
    // A start restarts the fade, or cancels it when the step is zero
    if (start) begin
      if (step_q == 0) begin
        fading_q = 1'b0;
      end else begin
        position_q = 0;
        fading_q = 1'b1;
        fades_begun++;
      end
    end
    if (fading_q) begin
      t = position_q + step_q;
      if (t > POS_ONE) t = POS_ONE;
      position_q = t;
      // Cubic ease on the distance from the nearer end, truncating
      u = (t < POS_HALF) ? t : POS_ONE - t;
      sq = (u * u) >> FRAC;
      cube = (sq * u) >> FRAC;
      ease = cube * 4;
      if (ease > POS_ONE) ease = POS_ONE;
      if (t >= POS_HALF) ease = POS_ONE - ease;
      // Scale the difference, round half away from zero, then saturate
      diff = longint'(curr) - longint'(prev);
      mag = (diff < 0) ? -diff : diff;
      term = (mag * ease + POS_HALF) >> FRAC;
      sum = (diff < 0) ? longint'(prev) - longint'(term) : longint'(prev) + longint'(term);
      if (sum > SMP_MAX) sum = SMP_MAX;
      if (sum < SMP_MIN) sum = SMP_MIN;
      if (t >= POS_ONE) begin
        fading_q = 1'b0;
        fades_done++;
      end
    end
    res.mixed = sum[SW-1:0];
    res.active = fading_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mixed_sample_t want;
    if (!rst_ni) begin
      step_q = 0;
      position_q = 0;
      fading_q = 1'b0;
      expected_mixes.delete();
      errors = 0;
      pending = 0;
      samples = 0;
      fades_begun = 0;
      fades_done = 0;
    end else begin
      // Predict on every accepted input transaction
      if (in_valid_i && !in_stall_i) begin
        expected_mixes.push_back(crossfade_sample(start_fade_i, prev_value_i, curr_value_i));
        samples++;
      end
      // Compare every accepted output transaction with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_mixes.size() == 0) begin
          errors++;
          $display("%0t: output transaction with nothing expected, got %0d/%0b",
                   $time, mixed_value_i, fade_active_i);
        end else begin
          want = expected_mixes.pop_front();
          if (mixed_value_i !== want.mixed) begin
            errors++;
            $display("%0t: mixed_value mismatch, expected %0d, got %0d",
                     $time, want.mixed, mixed_value_i);
          end
          if (fade_active_i !== want.active) begin
            errors++;
            $display("%0t: fade_active mismatch, expected %0b, got %0b",
                     $time, want.active, fade_active_i);
          end
        end
      end
      // A new step applies to later samples only
      if (cfg_we_i) step_q = longint'(cfg_wdata_i);
      pending = expected_mixes.size();
    end
  end

endmodule

>>> tb/eased_crossfade_tb.sv
// ----------------------------------------------------------------------------
// Eased crossfade testbench
// Drives directed and random sample streams through the crossfade under a
// range of fade steps, with random gaps and back-pressure, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module eased_crossfade_tb;
  import ecf_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FRAC = POS_FRAC_BITS_DEF;
  localparam logic [FRAC:0] STEP_ONE = {1'b1, {FRAC{1'b0}}};
  localparam logic [FRAC:0] STEP_MAX = '1;
  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam int TIMEOUT = 20_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [FRAC:0]        cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 start_fade_i = 1'b0;
  logic signed [SW-1:0] prev_value_i = '0;
  logic signed [SW-1:0] curr_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [SW-1:0] mixed_value_o;
  logic                 fade_active_o;
  logic                 steady = 1'b0;
  int                   error_count;
  int                   pending;
  int                   samples;
  int                   fades_begun;
  int                   fades_done;
  int                   step_writes = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  eased_crossfade DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_fade_i  (start_fade_i),
    .prev_value_i  (prev_value_i),
    .curr_value_i  (curr_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mixed_value_o (mixed_value_o),
    .fade_active_o (fade_active_o)
  );

  eased_crossfade_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .start_fade_i  (start_fade_i),
    .prev_value_i  (prev_value_i),
    .curr_value_i  (curr_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mixed_value_i (mixed_value_o),
    .fade_active_i (fade_active_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .samples_o     (samples),
    .fades_begun_o (fades_begun),
    .fades_done_o  (fades_done)
  );

  // Back-pressure on the output side, switched off in the steady stretch
  always @(negedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(99) < 35);
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT);
    $display("eased_crossfade test failed");
    $finish;
  end

  // Mostly random samples, with the range ends and the values around zero mixed in
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(11))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      3:       return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  // Mostly short fades, plus zero, exactly one, above one, tiny and full-width steps
  function automatic logic [FRAC:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return STEP_ONE;
      2:       return (FRAC+1)'($urandom_range(STEP_MAX, STEP_ONE + 1));
      3:       return (FRAC+1)'($urandom_range(STEP_MAX));
      4:       return (FRAC+1)'($urandom_range(64, 1));
      default: return (FRAC+1)'(STEP_ONE / $urandom_range(40, 2) + $urandom_range(255));
    endcase
  endfunction

  // Present one sample transaction and hold it until it is taken
  task automatic send_sample(input logic start, input logic signed [SW-1:0] prev,
                             input logic signed [SW-1:0] curr);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_fade_i <= start;
    prev_value_i <= prev;
    curr_value_i <= curr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending and wait until every predicted sample has come out
  task automatic drain(input int tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  // Write the fade step once the block is idle
  task automatic set_step(input logic [FRAC:0] step);
    drain(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= step;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    step_writes++;
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero step after reset: pass through, and a start only cancels
    send_sample(1'b0, SMP_MIN, SMP_MAX);
    send_sample(1'b1, SMP_MAX, SMP_MIN);

    // Four-sample fade across the half-way point, then a restart mid-fade
    set_step(STEP_ONE >> 2);
    send_sample(1'b1, SMP_MIN, SMP_MAX);
    send_sample(1'b0, SMP_MAX, SMP_MIN);
    send_sample(1'b0, '0, '1);
    send_sample(1'b0, '1, '0);
    send_sample(1'b0, 16'sd12345, -16'sd12345);
    send_sample(1'b1, SMP_MIN, SMP_MAX);
    send_sample(1'b1, SMP_MAX, SMP_MIN);

    // Step of exactly one and the largest step: the fade ends on its first sample
    set_step(STEP_ONE);
    send_sample(1'b1, 16'sd100, -16'sd200);
    set_step(STEP_MAX);
    send_sample(1'b1, SMP_MIN, SMP_MAX);

    // Tiny step, then zero step mid-fade: hold the mix until a start cancels
    set_step((FRAC+1)'(1));
    send_sample(1'b1, SMP_MAX, SMP_MIN);
    send_sample(1'b0, SMP_MIN, SMP_MAX);
    set_step('0);
    send_sample(1'b0, SMP_MAX, SMP_MIN);
    send_sample(1'b0, SMP_MIN, SMP_MAX);
    send_sample(1'b1, '0, '0);
    send_sample(1'b0, SMP_MIN, SMP_MIN);

    // Change the step mid-fade
    set_step((STEP_ONE >> 1) + 1'b1);
    send_sample(1'b1, SMP_MIN, SMP_MAX);
    set_step(STEP_ONE - 1'b1);
    send_sample(1'b0, SMP_MAX, SMP_MIN);
    send_sample(1'b0, SMP_MIN, SMP_MAX);

    // Random phases, each under a fresh step; two run without any idling
    for (int ph = 0; ph < 14; ph++) begin
      set_step(pick_step());
      steady <= (ph == 5 || ph == 6);
      n = $urandom_range(120, 90);
      for (int k = 0; k < n; k++)
        send_sample(($urandom_range(15) == 0) || (k == 0 && $urandom_range(1) == 1),
                    pick_sample(), pick_sample());
    end

    drain(100);
    $display("Ran %0d samples under %0d fade step settings", samples, step_writes);
    $display("Fades started: %0d, run to full level: %0d", fades_begun, fades_done);
    if (error_count == 0 && pending == 0) begin
      $display("eased_crossfade test passed");
    end else begin
      $display("eased_crossfade test failed");
    end
    $finish;
  end

endmodule

>>> eased_crossfade.f
+incdir+rtl/core
rtl/core/ecf_pkg.sv
rtl/core/eased_crossfade.sv
rtl/core/ecf_checker.sv
tb/eased_crossfade_checker.sv
tb/eased_crossfade_tb.sv
